// File: hw/rtl/assert_macros.svh
// assert_macros.svh: assertion macros for the RTL files.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SIST_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define SIST_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: hw/rtl/sist_pkg.sv
// sist_pkg: types and constants of the sorted integer set table.
// No dependencies.
package sist_pkg;

	localparam int unsigned DEPTH_DEF = 256;

	typedef enum logic [2:0] {
		FN_INSERT  = 3'd0,
		FN_READ    = 3'd1,
		FN_RMIDX   = 3'd2,
		FN_RMVAL   = 3'd3,
		FN_FIND    = 3'd4,
		FN_BEFORE  = 3'd5,
		FN_CLEAR   = 3'd6
	} func_t;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_NOTFOUND = 3'd1,
		STS_RANGE    = 3'd2,
		STS_FULL     = 3'd3,
		STS_DUP      = 3'd4
	} sts_t;

	// register select is paddr[2]
	localparam logic REG_SORTED = 1'b0;
	localparam logic REG_DUPOK  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DEC,
		ST_BS0,
		ST_BSL,
		ST_BSM,
		ST_ORD,
		ST_VER,
		ST_FOUND,
		ST_RDW,
		ST_SCAN,
		ST_INSCHK,
		ST_SHDN,
		ST_SHUP,
		ST_RESP
	} state_t;

endpackage

// File: hw/rtl/sorted_int_set_table.sv
// sorted_int_set_table: packed table of signed 32-bit integers with
// insert, read, remove, find, before and clear. Depends on sist_pkg and
// assert_macros.svh.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  item     | item_valid/item_ready  | func, value, position
//  result   | result_valid/ready     | status, index, entry_value, count
//  config   | APB psel/penable/pwrite| paddr, pwdata, prdata (pready high)
//
// Each word passes decode, an optional read, the response and idle, plus a
// binary search for a sorted table or a linear scan for an unsorted one,
// plus one move per entry shifted by an insert or remove and the finish steps.
// The single memory port pair (one read, one write a cycle) sets the pace.
// The worst case is an unsorted insert at index 0.
// Reset clears the count and both mode bits; the entry memory keeps its
// contents. A word is taken only in idle; the next word is taken while a
// finished result still waits in the output register.
module sorted_int_set_table #(
	parameter int unsigned DEPTH = sist_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// item channel
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [2:0]         func,
	input  logic signed [31:0] value,
	input  logic [8:0]         position,
	// result channel
	output logic               result_valid,
	input  logic               result_ready,
	output logic [2:0]         status,
	output logic [8:0]         index,
	output logic signed [31:0] entry_value,
	output logic [8:0]         count
);
	import sist_pkg::*;

	// count width: holds DEPTH and at least the 9-bit port fields
	localparam int unsigned CW0 = $clog2(DEPTH + 1);
	localparam int unsigned CW  = (CW0 > 9) ? CW0 : 9;
	localparam int unsigned AW  = $clog2(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	// configuration registers
	logic sorted_q, dupok_q;

	// control and datapath registers
	state_t              state_q, state_d;
	func_t               func_q;
	logic signed [31:0]  val_q;
	logic [CW-1:0]       pos_q, cnt_q, ptr_q, mid_q;
	logic signed [CW:0]  lo_q, hi_q;
	logic                vld_s1;
	logic [CW-1:0]       addr_s1;
	sts_t                sts_q;
	logic [CW-1:0]       ridx_q;
	logic signed [31:0]  rval_q;

	// output register
	logic                result_valid_q;
	sts_t                out_sts_q;
	logic [8:0]          out_idx_q, out_cnt_q;
	logic signed [31:0]  out_val_q;

	// entry memory, one read and one write port, registered read
	logic [31:0]         mem [DEPTH];
	logic                mem_re, mem_we;
	logic [AW-1:0]       mem_raddr, mem_waddr;
	logic [31:0]         mem_wdata;
	logic signed [31:0]  mem_rdata_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= $signed(mem[mem_raddr]);
		end
	end

	// APB: no wait states (pready held high), select by paddr[2]
	assign pready = 1'b1;
	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_DUPOK) begin
			prdata[0] = dupok_q;
		end else begin
			prdata[0] = sorted_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sorted_q <= 1'b0;
			dupok_q  <= 1'b0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_SORTED) begin
				sorted_q <= pwdata[0];
			end else begin
				dupok_q <= pwdata[0];
			end
		end
	end

	// compare helpers against the word's value
	logic eq_rv, less_rv, less_vr, match;
	assign eq_rv   = (mem_rdata_q == val_q);
	assign less_rv = (mem_rdata_q < val_q);
	assign less_vr = (val_q < mem_rdata_q);
	assign match   = vld_s1 && eq_rv;

	// neighbor addresses for the shift and before paths
	logic [CW-1:0]      pos_m1, ptr_m1, addr_m1, addr_p1;
	assign pos_m1  = pos_q - CW'(1);
	assign ptr_m1  = ptr_q - CW'(1);
	assign addr_m1 = addr_s1 - CW'(1);
	assign addr_p1 = addr_s1 + CW'(1);

	// binary search step
	logic [CW-1:0]      cnt_m1, mid0, bs_res;
	logic signed [CW:0] mid_x, lo_nx, hi_nx;
	logic [CW+1:0]      bs_sum;
	logic [CW-1:0]      mid_nx;
	logic               bs_cont, ord_verify, is_ins, slot_free;

	assign cnt_m1  = cnt_q - CW'(1);
	assign mid0    = cnt_m1 >> 1;
	assign mid_x   = $signed({1'b0, mid_q});
	assign lo_nx   = less_rv ? (mid_x + (CW+1)'(1)) : lo_q;
	assign hi_nx   = (!less_rv && !eq_rv) ? (mid_x - (CW+1)'(1)) : hi_q;
	assign bs_cont = (lo_nx <= hi_nx);
	assign bs_sum  = {lo_nx[CW], lo_nx} + {hi_nx[CW], hi_nx};
	assign mid_nx  = bs_sum[CW:1];
	// no equal entry hit: take the insertion point
	assign bs_res  = less_rv ? (mid_q + CW'(1)) : mid_q;

	assign is_ins     = (func_q == FN_INSERT);
	assign ord_verify = is_ins ? (!dupok_q && (pos_q < cnt_q)) : (pos_q < cnt_q);
	assign slot_free  = !result_valid_q || result_ready;

	assign item_ready = (state_q == ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_DEC;
			end
			ST_DEC: begin
				case (func_q)
					FN_INSERT: begin
						if (sorted_q) state_d = (cnt_q == '0) ? ST_ORD : ST_BS0;
						else if (pos_q > cnt_q) state_d = ST_RESP;
						else if (!dupok_q) state_d = ST_SCAN;
						else state_d = ST_INSCHK;
					end
					FN_READ, FN_RMIDX: begin
						state_d = (pos_q >= cnt_q) ? ST_RESP : ST_RDW;
					end
					FN_RMVAL, FN_FIND, FN_BEFORE: begin
						if (sorted_q) state_d = (cnt_q == '0) ? ST_ORD : ST_BS0;
						else state_d = ST_SCAN;
					end
					default: state_d = ST_RESP;
				endcase
			end
			ST_BS0:    state_d = less_vr ? ST_ORD : ST_BSL;
			ST_BSL:    state_d = less_rv ? ST_ORD : ST_BSM;
			ST_BSM:    state_d = (eq_rv || !bs_cont) ? ST_ORD : ST_BSM;
			ST_ORD: begin
				if (ord_verify) state_d = ST_VER;
				else state_d = is_ins ? ST_INSCHK : ST_RESP;
			end
			ST_VER: begin
				if (is_ins) state_d = eq_rv ? ST_RESP : ST_INSCHK;
				else state_d = eq_rv ? ST_FOUND : ST_RESP;
			end
			ST_FOUND: begin
				case (func_q)
					FN_RMVAL:  state_d = ST_SHDN;
					FN_BEFORE: state_d = (pos_q == '0) ? ST_RESP : ST_RDW;
					default:   state_d = ST_RESP;
				endcase
			end
			ST_RDW:    state_d = (func_q == FN_RMIDX) ? ST_SHDN : ST_RESP;
			ST_SCAN: begin
				if (match) state_d = is_ins ? ST_RESP : ST_FOUND;
				else if (ptr_q < cnt_q || vld_s1) state_d = ST_SCAN;
				else state_d = is_ins ? ST_INSCHK : ST_RESP;
			end
			ST_INSCHK: state_d = (cnt_q >= DEPTH_C) ? ST_RESP : ST_SHUP;
			ST_SHDN:   state_d = (ptr_q >= cnt_q && !vld_s1) ? ST_RESP : ST_SHDN;
			ST_SHUP:   state_d = (ptr_q <= pos_q && !vld_s1) ? ST_RESP : ST_SHUP;
			ST_RESP:   state_d = slot_free ? ST_IDLE : ST_RESP;
			default:   state_d = ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		unique case (state_q)
			ST_DEC: begin
				if ((func_q == FN_READ || func_q == FN_RMIDX) && pos_q < cnt_q) begin
					mem_re    = 1'b1;
					mem_raddr = pos_q[AW-1:0];
				end else if (sorted_q && cnt_q != '0 && (func_q == FN_INSERT ||
						func_q == FN_RMVAL || func_q == FN_FIND || func_q == FN_BEFORE)) begin
					mem_re = 1'b1;
				end
			end
			ST_BS0: begin
				mem_re    = !less_vr;
				mem_raddr = cnt_m1[AW-1:0];
			end
			ST_BSL: begin
				mem_re    = !less_rv;
				mem_raddr = mid0[AW-1:0];
			end
			ST_BSM: begin
				mem_re    = !eq_rv && bs_cont;
				mem_raddr = mid_nx[AW-1:0];
			end
			ST_ORD: begin
				mem_re    = ord_verify;
				mem_raddr = pos_q[AW-1:0];
			end
			ST_FOUND: begin
				mem_re    = (func_q == FN_BEFORE) && (pos_q != '0);
				mem_raddr = pos_m1[AW-1:0];
			end
			ST_SCAN: begin
				mem_re    = !match && (ptr_q < cnt_q);
				mem_raddr = ptr_q[AW-1:0];
			end
			ST_SHDN: begin
				// move entry k down to k-1 as it comes back
				mem_we    = vld_s1;
				mem_waddr = addr_m1[AW-1:0];
				mem_wdata = mem_rdata_q;
				mem_re    = (ptr_q < cnt_q);
				mem_raddr = ptr_q[AW-1:0];
			end
			ST_SHUP: begin
				// move entry k-1 up to k, then drop the new value in place
				mem_re    = (ptr_q > pos_q);
				mem_raddr = ptr_m1[AW-1:0];
				if (vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = addr_p1[AW-1:0];
					mem_wdata = mem_rdata_q;
				end else if (ptr_q <= pos_q) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q[AW-1:0];
					mem_wdata = val_q;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_DEC: begin
					vld_s1 <= 1'b0;
					if (func_q == FN_CLEAR) cnt_q <= '0;
				end
				ST_SCAN: begin
					vld_s1 <= !match && (ptr_q < cnt_q);
				end
				ST_SHDN: begin
					vld_s1 <= (ptr_q < cnt_q);
					if (ptr_q >= cnt_q && !vld_s1) cnt_q <= cnt_m1;
				end
				ST_SHUP: begin
					vld_s1 <= (ptr_q > pos_q);
					if (ptr_q <= pos_q && !vld_s1) cnt_q <= cnt_q + CW'(1);
				end
				default: begin
					vld_s1 <= 1'b0;
				end
			endcase
		end
	end

	// payload registers of the sequencer
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			func_q <= func_t'(func);
			val_q  <= value;
			pos_q  <= CW'(position);
		end
		unique case (state_q)
			ST_DEC: begin
				ridx_q <= '0;
				rval_q <= '0;
				ptr_q  <= '0;
				sts_q  <= STS_OK;
				if (func_q == FN_INSERT && !sorted_q && pos_q > cnt_q) sts_q <= STS_RANGE;
				if ((func_q == FN_READ || func_q == FN_RMIDX) && pos_q >= cnt_q) begin
					sts_q <= STS_RANGE;
				end
				if (sorted_q && cnt_q == '0) pos_q <= '0;
			end
			ST_BS0: begin
				if (less_vr) pos_q <= '0;
			end
			ST_BSL: begin
				if (less_rv) pos_q <= cnt_q;
				lo_q  <= '0;
				hi_q  <= $signed({1'b0, cnt_m1});
				mid_q <= mid0;
			end
			ST_BSM: begin
				lo_q  <= lo_nx;
				hi_q  <= hi_nx;
				mid_q <= mid_nx;
				if (eq_rv) pos_q <= mid_q;
				else if (!bs_cont) pos_q <= bs_res;
			end
			ST_ORD: begin
				if (!ord_verify && !is_ins) sts_q <= STS_NOTFOUND;
			end
			ST_VER: begin
				if (is_ins && eq_rv) sts_q <= STS_DUP;
				if (!is_ins && !eq_rv) sts_q <= STS_NOTFOUND;
			end
			ST_FOUND: begin
				if (func_q != FN_BEFORE) begin
					ridx_q <= pos_q;
					rval_q <= val_q;
					ptr_q  <= pos_q + CW'(1);
				end else if (pos_q == '0) begin
					sts_q <= STS_NOTFOUND;
				end else begin
					pos_q <= pos_m1;
				end
			end
			ST_RDW: begin
				ridx_q <= pos_q;
				rval_q <= mem_rdata_q;
				ptr_q  <= pos_q + CW'(1);
			end
			ST_SCAN: begin
				if (match) begin
					pos_q <= addr_s1;
					if (is_ins) sts_q <= STS_DUP;
				end else if (ptr_q < cnt_q) begin
					addr_s1 <= ptr_q;
					ptr_q   <= ptr_q + CW'(1);
				end else if (!vld_s1 && !is_ins) begin
					sts_q <= STS_NOTFOUND;
				end
			end
			ST_INSCHK: begin
				ptr_q <= cnt_q;
				if (cnt_q >= DEPTH_C) sts_q <= STS_FULL;
			end
			ST_SHDN: begin
				if (ptr_q < cnt_q) begin
					addr_s1 <= ptr_q;
					ptr_q   <= ptr_q + CW'(1);
				end
			end
			ST_SHUP: begin
				if (ptr_q > pos_q) begin
					addr_s1 <= ptr_m1;
					ptr_q   <= ptr_m1;
				end else if (!vld_s1) begin
					ridx_q <= pos_q;
					rval_q <= val_q;
				end
			end
			default: begin
			end
		endcase
	end

	// output register: load when the slot is free, hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && slot_free) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && slot_free) begin
			out_sts_q <= sts_q;
			out_idx_q <= ridx_q[8:0];
			out_val_q <= rval_q;
			out_cnt_q <= cnt_q[8:0];
		end
	end

	assign result_valid = result_valid_q;
	assign status       = out_sts_q;
	assign index        = out_idx_q;
	assign entry_value  = out_val_q;
	assign count        = out_cnt_q;

	`include "assert_macros.svh"

	`SIST_ASSERT_IMPLY(a_cnt_bound, 1'b1, cnt_q <= DEPTH_C)
	`SIST_ASSERT_IMPLY(a_mid_in_table, state_q == ST_BSM, mid_q < cnt_q)
	`SIST_ASSERT_IMPLY(a_write_only_shift, mem_we, state_q == ST_SHUP || state_q == ST_SHDN)
	`SIST_ASSERT_NEXT(a_cnt_holds, state_q != ST_SHUP && state_q != ST_SHDN && state_q != ST_DEC, $stable(cnt_q))

endmodule
